### hdl/d2i_pkg.sv
// ----------------------------------------------------------------------------
// d2i_pkg
// Shared types and constants for the double to saturating integer converter.
// ----------------------------------------------------------------------------
package d2i_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned WBITS_W = 7;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned EXP_W = 11;
    localparam int unsigned FRAC_W = 52;
    localparam int unsigned MANT_W = 53;
    localparam int unsigned VAL_W = 67;

    localparam logic [CFG_IDX_W-1:0] CFG_WORD_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_OFFSET = 2'd2;

    localparam logic [EXP_W-1:0] EXP_ALL_ONES = 11'h7ff;
    localparam logic [WORD_W-1:0] ALL_ONES = 64'hffffffffffffffff;

    typedef struct packed {
        logic [WBITS_W-1:0] word_bits;
        logic               signed_mode;
        logic [WORD_W-1:0]  int_offset;
    } t_cfg;

    // stage 1 to stage 2
    typedef struct packed {
        logic              is_nan;
        logic              huge;
        logic              neg;
        logic [WORD_W:0]   mag;
        logic              last;
    } t_rnd;

    // stage 2 to stage 3
    typedef struct packed {
        logic              is_nan;
        logic              huge;
        logic              neg;
        logic [VAL_W-1:0]  diff;
        logic [WORD_W-1:0] maxv;
        logic [WORD_W-1:0] minv;
        logic              sgn;
        logic              last;
    } t_sub;

endpackage

### hdl/d2i_if.sv
// ----------------------------------------------------------------------------
// d2i_in_if / d2i_out_if / d2i_cfg_if
// Valid/ready channels of the converter.
// ----------------------------------------------------------------------------
interface d2i_in_if;
    logic                            valid;
    logic                            ready;
    logic [d2i_pkg::WORD_W-1:0]      double_bits;
    logic                            last_element;
    modport source (output valid, double_bits, last_element, input ready);
    modport sink   (input valid, double_bits, last_element, output ready);
endinterface

interface d2i_out_if;
    logic                            valid;
    logic                            ready;
    logic [d2i_pkg::WORD_W-1:0]      raw_word;
    logic                            last_out;
    modport source (output valid, raw_word, last_out, input ready);
    modport sink   (input valid, raw_word, last_out, output ready);
endinterface

interface d2i_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [d2i_pkg::CFG_IDX_W-1:0]   index;
    logic [d2i_pkg::WORD_W-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/double_to_int_saturating_core.sv
// ----------------------------------------------------------------------------
// double_to_int_saturating_core
// Rounds an IEEE-754 double to an integer (ties away), subtracts an offset
// exactly and saturates into a signed or unsigned word of 1..64 bits.
//
// Channels: in_ch takes double_bits and last_element, out_ch gives raw_word
// and last_out, cfg_ch writes word_bits (0), signed_mode (1), int_offset (2).
// A request is taken when valid and ready are both high.
// The result passes three register stages, round, subtract and clamp; one item
// per cycle is sustained while the receiver does not stall.
// The output stage is a register that holds while the receiver stalls; the
// pipeline advances whenever the last stage is empty or being taken, so a
// stall backs up without loss or repeat.
// Reset empties the pipeline and sets word_bits 32, unsigned, offset 0.
// cfg_ch is always ready; the user makes writes while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module double_to_int_saturating_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    d2i_in_if.sink     in_ch,
    d2i_out_if.source  out_ch,
    d2i_cfg_if.sink    cfg_ch
);

    d2i_pkg::t_cfg r_cfg;
    d2i_pkg::t_rnd n_rnd;
    d2i_pkg::t_rnd r_rnd;
    d2i_pkg::t_sub n_sub;
    d2i_pkg::t_sub r_sub;
    logic [d2i_pkg::WORD_W-1:0] n_word;
    logic [d2i_pkg::WORD_W-1:0] r_word;
    logic r_last;
    logic r_v1, r_v2, r_v3;
    logic adv;
    logic [d2i_pkg::WBITS_W-1:0] w;
    logic [d2i_pkg::VAL_W-1:0]   val;
    logic [d2i_pkg::VAL_W-1:0]   off;

    assign adv          = !r_v3 || out_ch.ready;
    assign in_ch.ready  = adv;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_v3;
    assign out_ch.raw_word = r_word;
    assign out_ch.last_out = r_last;

    d2i_round u_round (
        .i_bits (in_ch.double_bits),
        .i_last (in_ch.last_element),
        .o_rnd  (n_rnd)
    );

    always_comb begin
        w = r_cfg.word_bits;
        if (w == '0) w = 7'd1;
        if (w > 7'd64) w = 7'd64;
        val = {2'b00, r_rnd.mag};
        if (r_rnd.neg) val = ~val + 67'd1;
        off = {{3{r_cfg.signed_mode & r_cfg.int_offset[63]}}, r_cfg.int_offset};
        n_sub.is_nan = r_rnd.is_nan;
        n_sub.huge   = r_rnd.huge;
        n_sub.neg    = r_rnd.neg;
        n_sub.diff   = val - off;
        n_sub.sgn    = r_cfg.signed_mode;
        n_sub.last   = r_rnd.last;
        if (r_cfg.signed_mode) begin
            n_sub.maxv = d2i_pkg::ALL_ONES >> (7'd65 - w);
            n_sub.minv = ~n_sub.maxv;
        end else begin
            n_sub.maxv = d2i_pkg::ALL_ONES >> (7'd64 - w);
            n_sub.minv = '0;
        end
    end

    d2i_clamp u_clamp (
        .i_sub  (r_sub),
        .o_word (n_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_cfg.word_bits   <= 7'd32;
            r_cfg.signed_mode <= 1'b0;
            r_cfg.int_offset  <= '0;
        end else begin
            if (cfg_ch.valid) begin
                case (cfg_ch.index)
                    d2i_pkg::CFG_WORD_BITS:   r_cfg.word_bits <= cfg_ch.data[6:0];
                    d2i_pkg::CFG_SIGNED_MODE: r_cfg.signed_mode <= cfg_ch.data[0];
                    d2i_pkg::CFG_INT_OFFSET:  r_cfg.int_offset <= cfg_ch.data;
                    default: ;
                endcase
            end
            if (adv) begin
                r_v1 <= in_ch.valid;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rnd  <= n_rnd;
            r_sub  <= n_sub;
            r_word <= n_word;
            r_last <= r_sub.last;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !out_ch.ready |=> r_v3 && $stable(r_word))
        else $error("result lost under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v3 |-> in_ch.ready)
        else $error("input blocked with empty output");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_v2 |=> r_v3)
        else $error("item dropped in pipeline");

endmodule

### hdl/d2i_round.sv
// ----------------------------------------------------------------------------
// d2i_round
// Decodes the double and rounds its magnitude to an integer, ties away.
// ----------------------------------------------------------------------------
module d2i_round (
    input  logic [d2i_pkg::WORD_W-1:0] i_bits,
    input  logic                       i_last,
    output d2i_pkg::t_rnd              o_rnd
);

    logic [d2i_pkg::EXP_W-1:0]  ex;
    logic [d2i_pkg::FRAC_W-1:0] frac;
    logic [d2i_pkg::MANT_W-1:0] mant;
    logic [d2i_pkg::EXP_W-1:0]  e;
    logic [d2i_pkg::EXP_W-1:0]  k;
    logic [d2i_pkg::EXP_W-1:0]  s;
    logic [d2i_pkg::WORD_W:0]   wide;
    logic [d2i_pkg::MANT_W-1:0] ip;
    logic                       half;

    always_comb begin
        ex   = i_bits[62:52];
        frac = i_bits[51:0];
        mant = {(ex != '0), frac};
        e    = (ex != '0) ? ex : 11'd1;
        k    = e - 11'd1075;
        s    = 11'd1075 - e;
        wide = '0;
        ip   = '0;
        half = 1'b0;
        o_rnd.is_nan = (ex == d2i_pkg::EXP_ALL_ONES) && (frac != '0);
        o_rnd.huge   = (ex == d2i_pkg::EXP_ALL_ONES);
        o_rnd.neg    = i_bits[63];
        o_rnd.last   = i_last;
        if (e >= 11'd1075) begin
            if (k > 11'd12) begin
                o_rnd.huge = 1'b1;
            end else begin
                wide = {12'd0, mant} << k[3:0];
            end
        end else if (s <= 11'd54) begin
            ip   = (s >= 11'd54) ? '0 : (mant >> s[5:0]);
            half = (s == 11'd54) ? 1'b0 : mant[s[5:0] - 6'd1];
            wide = {12'd0, ip} + {64'd0, half};
        end
        o_rnd.mag = wide;
    end

endmodule

### hdl/d2i_clamp.sv
// ----------------------------------------------------------------------------
// d2i_clamp
// Compares the exact difference against the word limits and saturates.
// ----------------------------------------------------------------------------
module d2i_clamp (
    input  d2i_pkg::t_sub               i_sub,
    output logic [d2i_pkg::WORD_W-1:0]  o_word
);

    logic signed [d2i_pkg::VAL_W-1:0] d;
    logic signed [d2i_pkg::VAL_W-1:0] mx;
    logic signed [d2i_pkg::VAL_W-1:0] mn;

    always_comb begin
        d  = i_sub.diff;
        mx = {3'b000, i_sub.maxv};
        mn = i_sub.sgn ? {{3{1'b1}}, i_sub.minv} : '0;
        if (i_sub.is_nan) begin
            o_word = '0;
        end else if (i_sub.huge) begin
            o_word = i_sub.neg ? mn[d2i_pkg::WORD_W-1:0] : i_sub.maxv;
        end else if (d > mx) begin
            o_word = i_sub.maxv;
        end else if (d < mn) begin
            o_word = mn[d2i_pkg::WORD_W-1:0];
        end else begin
            o_word = d[d2i_pkg::WORD_W-1:0];
        end
    end

endmodule
